// File: rtl/sha_pkg.sv
// Package with SHA-256 constants, types and round functions.
package sha_pkg;

  localparam int unsigned QueueDepth = 4;

  typedef enum logic [1:0] {
    CMD_BYTE = 2'd0,
    CMD_LAST = 2'd1
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    logic [7:0] data;
    logic       has_byte;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_FILL  = 3'd0,
    ST_ROUND = 3'd1,
    ST_FOLD  = 3'd2,
    ST_PAD   = 3'd3,
    ST_EMIT  = 3'd4
  } core_state_t;

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] sig0(input logic [31:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] sig1(input logic [31:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

// File: rtl/sha_front.sv
// Input classifier and command queue between stream input and hash core.
module sha_front #(
  parameter int unsigned Depth = sha_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tuser,
  input  logic          in_tlast,
  output logic          cmd_valid,
  input  logic          cmd_ready,
  output sha_pkg::cmd_t cmd
);
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  sha_pkg::cmd_t    mem_r [Depth];
  logic [Aw-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [Aw:0]      count_r, count_nxt;
  logic             push, pop, keep;
  sha_pkg::cmd_t    new_cmd;

  // drop empty non-last items here
  assign keep      = in_tuser | in_tlast;
  assign in_tready = (count_r != Aw'(0) + (Aw+1)'(Depth)) ;
  assign push      = in_tvalid & in_tready & keep;
  assign pop       = cmd_valid & cmd_ready;
  assign cmd_valid = (count_r != '0);
  assign cmd       = mem_r[rd_ptr_r];

  always_comb begin
    new_cmd.kind     = in_tlast ? sha_pkg::CMD_LAST : sha_pkg::CMD_BYTE;
    new_cmd.data     = in_tdata;
    new_cmd.has_byte = in_tuser;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == Aw'(Depth - 1)) ? '0 : wr_ptr_r + 1'b1;
    if (pop)  rd_ptr_nxt = (rd_ptr_r == Aw'(Depth - 1)) ? '0 : rd_ptr_r + 1'b1;
    count_nxt = count_r + (Aw+1)'(push) - (Aw+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= new_cmd;
  end
endmodule

// File: rtl/sha_core.sv
// Block assembly, padding, 64-round compression and digest output.
module sha_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  sha_pkg::cmd_t cmd,
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,
  output logic [2:0]    out_tuser,
  output logic          out_tlast
);
  sha_pkg::core_state_t state_r, state_nxt;
  logic [31:0] w_r [16];
  logic [31:0] h_r [8];
  logic [31:0] v_r [8];
  logic [5:0]  bcnt_r;
  logic [60:0] mcnt_r;
  logic [5:0]  rnd_r;
  logic [3:0]  pcnt_r;
  logic [2:0]  oidx_r;
  logic        final_r;

  logic        accept, put, blk_full;
  logic [7:0]  put_byte;
  logic [63:0] bits;
  logic [31:0] wj, wnew, t1, t2;
  logic [3:0]  j;
  logic [5:0]  pad_pos;

  assign accept = cmd_valid & cmd_ready;
  assign bits   = {mcnt_r, 3'b000};
  assign j      = rnd_r[3:0];
  assign pad_pos = bcnt_r;

  // byte to place in this cycle
  always_comb begin
    put      = 1'b0;
    put_byte = cmd.data;
    if (state_r == sha_pkg::ST_FILL && accept && cmd.has_byte) begin
      put = 1'b1;
    end else if (state_r == sha_pkg::ST_PAD) begin
      put = 1'b1;
      if (pcnt_r == 4'd0)          put_byte = 8'h80;
      else if (pcnt_r < 4'd8)      put_byte = 8'h00;
      else                         put_byte = bits[{~pcnt_r[2:0], 3'b111} -: 8];
    end
  end
  assign blk_full = put & (bcnt_r == 6'd63);

  always_comb begin
    wnew = w_r[j] + sha_pkg::sig0(w_r[j + 4'd1]) + w_r[j + 4'd9] + sha_pkg::sig1(w_r[j + 4'd14]);
    wj   = (rnd_r >= 6'd16) ? wnew : w_r[j];
    t1   = v_r[7] + sha_pkg::bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
           + sha_pkg::RoundK[rnd_r] + wj;
    t2   = sha_pkg::bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));
  end

  always_comb begin
    unique case (state_r)
      sha_pkg::ST_FILL: cmd_ready = 1'b1;
      default:          cmd_ready = 1'b0;
    endcase
    out_tvalid = (state_r == sha_pkg::ST_EMIT);
    out_tdata  = h_r[oidx_r];
    out_tuser  = oidx_r;
    out_tlast  = (oidx_r == 3'd7);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sha_pkg::ST_FILL: begin
        if (blk_full) state_nxt = sha_pkg::ST_ROUND;
        else if (accept && cmd.kind == sha_pkg::CMD_LAST) state_nxt = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_PAD: begin
        if (blk_full) state_nxt = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: if (rnd_r == 6'd63) state_nxt = sha_pkg::ST_FOLD;
      sha_pkg::ST_FOLD: begin
        if (!final_r)                state_nxt = sha_pkg::ST_FILL;
        else if (pcnt_r == 4'd15)   state_nxt = sha_pkg::ST_EMIT;
        else                         state_nxt = sha_pkg::ST_PAD;
      end
      sha_pkg::ST_EMIT: if (out_tready && oidx_r == 3'd7) state_nxt = sha_pkg::ST_FILL;
      default: state_nxt = sha_pkg::ST_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha_pkg::ST_FILL;
      bcnt_r  <= '0;
      mcnt_r  <= '0;
      rnd_r   <= '0;
      pcnt_r  <= '0;
      oidx_r  <= '0;
      final_r <= 1'b0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitHash[i];
    end else begin
      state_r <= state_nxt;
      if (put) bcnt_r <= bcnt_r + 6'd1;
      if (state_r == sha_pkg::ST_FILL && accept) begin
        if (cmd.has_byte) mcnt_r <= mcnt_r + 61'd1;
        if (cmd.kind == sha_pkg::CMD_LAST) begin
          final_r <= 1'b1;
          pcnt_r  <= '0;
        end
      end
      // pcnt: 0 before 0x80, 1 zeros, 8..15 length bytes, hold at 15 once done
      if (state_r == sha_pkg::ST_PAD) begin
        if (pcnt_r >= 4'd8) begin
          if (pcnt_r != 4'd15) pcnt_r <= pcnt_r + 4'd1;
        end else begin
          pcnt_r <= (pad_pos == 6'd55) ? 4'd8 : 4'd1;
        end
      end
      if (state_r == sha_pkg::ST_ROUND) rnd_r <= rnd_r + 6'd1;
      if (state_r == sha_pkg::ST_FOLD) begin
        for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
      end
      if (state_r == sha_pkg::ST_EMIT && out_tready) begin
        oidx_r <= oidx_r + 3'd1;
        if (oidx_r == 3'd7) begin
          final_r <= 1'b0;
          bcnt_r  <= '0;
          mcnt_r  <= '0;
          for (int i = 0; i < 8; i++) h_r[i] <= sha_pkg::InitHash[i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      if (bcnt_r[1:0] == 2'd0) w_r[bcnt_r[5:2]] <= {put_byte, 24'h0};
      else w_r[bcnt_r[5:2]][8'(31 - 8 * int'(bcnt_r[1:0])) -: 8] <= put_byte;
    end
    if (state_r == sha_pkg::ST_ROUND) begin
      w_r[j] <= wj;
      v_r[7] <= v_r[6];
      v_r[6] <= v_r[5];
      v_r[5] <= v_r[4];
      v_r[4] <= v_r[3] + t1;
      v_r[3] <= v_r[2];
      v_r[2] <= v_r[1];
      v_r[1] <= v_r[0];
      v_r[0] <= t1 + t2;
    end
    if (blk_full) begin
      for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
    end
  end
endmodule

// File: rtl/sha256_hash_engine.sv
// Top level of the SHA-256 hash engine.
// Bytes enter at one per cycle, while the command queue has room, into that small
// queue; a full 64-byte block is then compressed one round per cycle through the
// single round unit and the sums are folded, while input is queued and then held.
// On the last item padding places one byte per cycle up to the end of the block;
// when 56 or more message bytes sit in that block a second, all-padding block of
// 64 bytes follows after the first one is compressed. Each padded block is
// compressed like a data block, after which eight digest words leave at one per
// cycle, H0 first, holding while out_tready is low. The core takes no new
// command until the eighth word has left; the queue takes input while it has room.
module sha256_hash_engine #(
  parameter int unsigned QueueDepth = sha_pkg::QueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // msg_byte
  input  logic        in_tuser,   // byte_valid
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // digest_word
  output logic [2:0]  out_tuser,  // word_index
  output logic        out_tlast
);
  logic          cmd_valid, cmd_ready;
  sha_pkg::cmd_t cmd;

  sha_front #(.Depth(QueueDepth)) u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser, .in_tlast,
    .cmd_valid, .cmd_ready, .cmd
  );

  sha_core u_core (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
  );
endmodule

// File: rtl/sha_checker.sv
// Port-level checks for the SHA-256 hash engine.
module sha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tuser == 3'd7))) else $error("last flag mismatch");
  a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> (out_tvalid && out_tuser == $past(out_tuser) + 3'd1))
    else $error("word index skip");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("output changed while stalled");
endmodule

bind sha256_hash_engine sha_checker u_sha_checker (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast
);

// File: sim/tb_sha256_hash_engine.sv
// Self-checking testbench for sha256_hash_engine: directed and random byte-stream messages against a SHA-256 predictor.
module tb_sha256_hash_engine;

  typedef struct packed {
    logic [7:0] msg_byte;
    logic       byte_valid;
    logic       last;
  } msg_item_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_word;
  } digest_item_t;

  localparam logic [31:0] IvWords [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] KWords [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam int unsigned CycleLimit = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  msg_item_t    pending_items [$];
  digest_item_t expected_digest [$];
  int unsigned  errors;
  int unsigned  cycles;
  int unsigned  send_wait;
  int unsigned  recv_wait;
  bit           stimulus_done;
  bit           hold_for_drain;
  bit           drain_done;
  bit           in_fire;
  bit           out_fire;

  logic [31:0] hash_state [8];
  logic [31:0] block_words [16];
  logic [5:0]  block_fill;
  logic [60:0] msg_len;

  sha256_hash_engine u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  function automatic logic [31:0] ror32(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] v [8];
    logic [31:0] w [64];
    logic [31:0] t1, t2, s0, s1;
    for (int i = 0; i < 16; i++) w[i] = block_words[i];
    for (int i = 16; i < 64; i++) begin
      s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
      s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
      w[i] = w[i-16] + s0 + w[i-7] + s1;
    end
    for (int i = 0; i < 8; i++) v[i] = hash_state[i];
    for (int r = 0; r < 64; r++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KWords[r] + w[r];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_state[i] += v[i];
  endtask

  task automatic absorb_byte(logic [7:0] b);
    int idx;
    idx = block_fill;
    if (idx[1:0] == 2'd0) block_words[idx >> 2] = {b, 24'd0};
    else block_words[idx >> 2] |= 32'(b) << (24 - 8 * idx[1:0]);
    block_fill = block_fill + 6'd1;
    if (block_fill == 6'd0) compress_block();
  endtask

  task automatic predict_digest(msg_item_t it);
    logic [63:0] bits;
    digest_item_t d;
    if (it.byte_valid) begin
      absorb_byte(it.msg_byte);
      msg_len = msg_len + 61'd1;
    end
    if (it.last) begin
      bits = {msg_len, 3'b000};
      absorb_byte(8'h80);
      while (block_fill != 6'd56) absorb_byte(8'h00);
      for (int i = 0; i < 8; i++) absorb_byte(bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.word = hash_state[i];
        d.index = 3'(i);
        d.last_word = (i == 7);
        expected_digest.push_back(d);
      end
      for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
      block_fill = '0;
      msg_len = '0;
    end
  endtask

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    errors++;
  endtask

  function automatic void queue_message(int len, bit empty_tail, bit with_gaps);
    msg_item_t it;
    for (int i = 0; i < len; i++) begin
      if (with_gaps && $urandom_range(0, 7) == 0) begin
        it.msg_byte = 8'($urandom);
        it.byte_valid = 1'b0;
        it.last = 1'b0;
        pending_items.push_back(it);
      end
      it.msg_byte = 8'($urandom);
      it.byte_valid = 1'b1;
      it.last = (i == len - 1) && !empty_tail;
      pending_items.push_back(it);
    end
    if (empty_tail || len == 0) begin
      it.msg_byte = 8'($urandom);
      it.byte_valid = 1'b0;
      it.last = 1'b1;
      pending_items.push_back(it);
    end
  endfunction

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    msg_item_t it;
    // directed: empty, extreme bytes, empty tail; random lengths near padding boundaries follow
    queue_message(0, 1'b1, 1'b0);
    it = '{msg_byte: 8'h00, byte_valid: 1'b1, last: 1'b0}; pending_items.push_back(it);
    it = '{msg_byte: 8'hff, byte_valid: 1'b1, last: 1'b0}; pending_items.push_back(it);
    it = '{msg_byte: 8'h55, byte_valid: 1'b0, last: 1'b0}; pending_items.push_back(it);
    it = '{msg_byte: 8'haa, byte_valid: 1'b1, last: 1'b1}; pending_items.push_back(it);
    queue_message(3, 1'b1, 1'b0);
    while (pending_items.size() < 180) begin
      case ($urandom_range(0, 5))
        0: queue_message($urandom_range(55, 57), $urandom_range(0, 1), 1'b0);
        1: queue_message($urandom_range(63, 65), $urandom_range(0, 1), 1'b0);
        2: queue_message(0, 1'b1, 1'b0);
        default: queue_message($urandom_range(1, 12), $urandom_range(0, 3) == 0, 1'b1);
      endcase
    end
  end

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = 1'b0;
    in_tlast = 1'b0;
    out_tready = 1'b0;
    errors = 0;
    cycles = 0;
    send_wait = 0;
    recv_wait = 0;
    stimulus_done = 1'b0;
    hold_for_drain = 1'b0;
    for (int i = 0; i < 8; i++) hash_state[i] = IvWords[i];
    for (int i = 0; i < 16; i++) block_words[i] = '0;
    block_fill = '0;
    msg_len = '0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
  end

  // driver
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && !in_fire) begin
        in_tvalid <= 1'b1;
      end else if (send_wait != 0) begin
        in_tvalid <= 1'b0;
        send_wait <= send_wait - 1;
      end else if (hold_for_drain) begin
        in_tvalid <= 1'b0;
        if (expected_digest.size() == 0) begin
          hold_for_drain <= 1'b0;
          drain_done <= 1'b1;
        end
      end else if (pending_items.size() != 0) begin
        msg_item_t it;
        it = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata <= it.msg_byte;
        in_tuser <= it.byte_valid;
        in_tlast <= it.last;
        hold_for_drain <= it.last && !drain_done && (pending_items.size() <= 120);
        send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 6) : 0;
      end else begin
        in_tvalid <= 1'b0;
        stimulus_done <= 1'b1;
      end
      if (out_fire || !out_tready) begin
        if (recv_wait != 0) begin
          out_tready <= 1'b0;
          recv_wait <= recv_wait - 1;
        end else begin
          out_tready <= 1'b1;
          recv_wait <= ($urandom_range(0, 2) == 0) ? $urandom_range(0, 6) : 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    cycles <= cycles + 1;
    in_fire <= rst_n && in_tvalid && in_tready;
    out_fire <= rst_n && out_tvalid && out_tready;
    if (rst_n && in_tvalid && in_tready) begin
      msg_item_t it;
      it.msg_byte = in_tdata;
      it.byte_valid = in_tuser;
      it.last = in_tlast;
      predict_digest(it);
    end
    if (rst_n && out_tvalid && out_tready) begin
      digest_item_t e;
      if (expected_digest.size() == 0) begin
        report_mismatch("unexpected digest word");
      end else begin
        e = expected_digest.pop_front();
        if (out_tdata !== e.word)
          report_mismatch($sformatf("word %h, expected %h", out_tdata, e.word));
        if (out_tuser !== e.index)
          report_mismatch($sformatf("index %0d, expected %0d", out_tuser, e.index));
        if (out_tlast !== e.last_word)
          report_mismatch($sformatf("tlast %b, expected %b", out_tlast, e.last_word));
      end
    end
  end

  initial begin
    do @(posedge clk); while (!(stimulus_done && expected_digest.size() == 0));
    repeat (200) @(posedge clk);
    if (errors == 0 && expected_digest.size() == 0) begin
      $display("** sha256_hash_engine: PASSED **");
    end else begin
      $display("** sha256_hash_engine: FAILED **");
    end
    $finish;
  end

  initial begin
    wait (cycles >= CycleLimit);
    $display("timeout with %0d digest words outstanding", expected_digest.size());
    $display("** sha256_hash_engine: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sha_pkg.sv
rtl/sha_front.sv
rtl/sha_core.sv
rtl/sha256_hash_engine.sv
rtl/sha_checker.sv
sim/tb_sha256_hash_engine.sv
